### hw/rtl/gram_matrix_forward_unit_defines.svh
// assertion macros for the gram matrix forward unit
// expects i_clk and i_rst_n in the scope of each use
`ifndef GRAM_MATRIX_FORWARD_UNIT_DEFINES_SVH
`define GRAM_MATRIX_FORWARD_UNIT_DEFINES_SVH

// same-cycle implication
`define GMF_AST_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gmf assertion failed");

// next-cycle implication
`define GMF_AST_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gmf assertion failed");

`endif

### hw/rtl/gmf_pkg.sv
// shared types and constants for the gram matrix forward unit
// no dependencies
package gmf_pkg;

    localparam int FEAT_W     = 16;
    localparam int OUT_W      = 32;
    localparam int IDX_OUT_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int CHAN_FLD_W = 4;

    typedef logic signed [FEAT_W-1:0] t_feature;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNELS  = 2'd0,
        CFG_POSITIONS = 2'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_LOAD,
        S_MAC,
        S_DRAIN,
        S_DIV
    } t_state;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctrl;

endpackage

### hw/rtl/gmf_ram.sv
// generic ram, one write port and two registered read ports
// no dependencies
module gmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                       o_rdata_a,
    output logic [WIDTH-1:0]                       o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### hw/rtl/gmf_mac.sv
// multiply-accumulate unit, registered product then accumulate
// depends on gmf_pkg
module gmf_mac #(
    parameter int ACC_W = 39
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  gmf_pkg::t_mac_ctrl      i_ctrl,
    input  gmf_pkg::t_feature       i_a,
    input  gmf_pkg::t_feature       i_b,
    output logic signed [ACC_W-1:0] o_acc,
    output logic                    o_idle
);
    import gmf_pkg::*;

    localparam int PROD_W = 2 * FEAT_W;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_idle = !r_prod_vld;

endmodule

### hw/rtl/gmf_div.sv
// serial restoring divider, signed dividend by unsigned divisor, one bit per cycle
// truncates toward zero; no dependencies
module gmf_div #(
    parameter int DVD_W = 39,
    parameter int DVS_W = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0] rem_sh;
    logic           ge;
    logic [DVS_W:0] rem_nx;

    assign rem_sh = {r_rem, r_quo[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};
    assign rem_nx = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DVD_W-1];
            r_quo <= i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : DVD_W'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= rem_nx[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

endmodule

### hw/rtl/gram_matrix_forward_unit.sv
// gram matrix forward unit: stores one feature map, then emits the normalized gram matrix
// depends on gmf_pkg, gmf_ram, gmf_mac, gmf_div and gram_matrix_forward_unit_defines.svh
//
// channel   | direction | handshake                 | payload
// feature   | in        | i_start / o_busy          | i_feature
// result    | out       | o_result_valid strobe     | o_gram_value, o_row_index, o_col_index,
//           |           |                           | o_last_entry
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// loading takes one cycle per element while i_start is held high, C*H elements per sample
// after the last element, the C*C entries are computed one after another, each by
// H reads through the single mac, a drain of the mac pipeline and the serial divider,
// with o_busy high throughout
// reset is synchronous, active low; no clearing pass, the store is filled before any read
// results are strobed for one cycle each and cannot be stalled
module gram_matrix_forward_unit #(
    parameter int MAX_CHANNELS  = 8,
    parameter int MAX_POSITIONS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  gmf_pkg::t_feature                   i_feature,
    output logic                                o_result_valid,
    output logic signed [gmf_pkg::OUT_W-1:0]    o_gram_value,
    output logic [gmf_pkg::IDX_OUT_W-1:0]       o_row_index,
    output logic [gmf_pkg::IDX_OUT_W-1:0]       o_col_index,
    output logic                                o_last_entry,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gmf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gmf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import gmf_pkg::*;

    localparam int CW      = $clog2(MAX_CHANNELS + 1);
    localparam int IW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PW      = $clog2(MAX_POSITIONS + 1);
    localparam int DEPTH   = MAX_CHANNELS * MAX_POSITIONS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW      = $clog2(DEPTH + 1);
    localparam int ACC_W   = 2 * FEAT_W + PW;
    localparam int POS_RST = (MAX_POSITIONS < 64) ? MAX_POSITIONS : 64;

    t_state r_state;
    t_state n_state;

    logic [CW-1:0] r_c;
    logic [PW-1:0] r_h;
    logic [TW-1:0] total;
    logic [TW-1:0] r_load_cnt;

    logic [IW-1:0] r_row;
    logic [IW-1:0] r_col;
    logic [AW-1:0] r_base_i;
    logic [AW-1:0] r_base_j;
    logic [AW-1:0] r_addr_a;
    logic [AW-1:0] r_addr_b;
    logic [PW-1:0] r_pos;
    logic          r_rd_vld;

    logic                    r_res_vld;
    logic signed [OUT_W-1:0] r_value;
    logic [IDX_OUT_W-1:0]    r_row_o;
    logic [IDX_OUT_W-1:0]    r_col_o;
    logic                    r_last;

    logic [CHAN_FLD_W-1:0] cfg_c;
    logic [CW-1:0]         c_clamped;
    logic [PW-1:0]         h_clamped;
    logic                  cfg_fire;
    logic                  cfg_known;
    logic                  item_fire;
    logic                  load_last;
    logic                  row_last;
    logic                  col_last;
    logic                  entry_last;
    logic                  pos_last;
    logic                  pipe_empty;

    t_mac_ctrl                mac_ctrl;
    logic signed [ACC_W-1:0]  acc;
    logic                     mac_idle;
    logic                     div_start;
    logic                     div_done;
    logic signed [ACC_W-1:0]  quo;
    logic [FEAT_W-1:0]        rdata_a;
    logic [FEAT_W-1:0]        rdata_b;

    assign o_busy      = (r_state != S_LOAD);
    assign o_cfg_ready = !o_busy && !i_start;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign cfg_known   = (i_cfg_index == CFG_CHANNELS) || (i_cfg_index == CFG_POSITIONS);
    assign item_fire   = i_start && !o_busy;

    assign total      = TW'(r_c) * TW'(r_h);
    assign load_last  = item_fire && (r_load_cnt == total - TW'(1));
    assign row_last   = (r_row == IW'(r_c - CW'(1)));
    assign col_last   = (r_col == IW'(r_c - CW'(1)));
    assign entry_last = row_last && col_last;
    assign pos_last   = (r_pos == r_h - PW'(1));
    assign pipe_empty = !r_rd_vld && mac_idle;

    // register clamping
    assign cfg_c = i_cfg_data[CHAN_FLD_W-1:0];

    always_comb begin
        if (cfg_c == '0) begin
            c_clamped = CW'(1);
        end else if (32'(cfg_c) > MAX_CHANNELS) begin
            c_clamped = CW'(MAX_CHANNELS);
        end else begin
            c_clamped = CW'(cfg_c);
        end
    end

    always_comb begin
        if (i_cfg_data == '0) begin
            h_clamped = PW'(1);
        end else if (32'(i_cfg_data) > MAX_POSITIONS) begin
            h_clamped = PW'(MAX_POSITIONS);
        end else begin
            h_clamped = PW'(i_cfg_data);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (load_last) n_state = S_MAC;
            end
            S_MAC: begin
                if (pos_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (pipe_empty) n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) n_state = entry_last ? S_LOAD : S_MAC;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // sequencer outputs
    always_comb begin
        div_start      = 1'b0;
        mac_ctrl.clear = 1'b0;
        mac_ctrl.valid = r_rd_vld;
        unique case (r_state)
            S_LOAD:  mac_ctrl.clear = load_last;
            S_DRAIN: begin
                div_start      = pipe_empty;
                mac_ctrl.clear = pipe_empty;
            end
            S_MAC, S_DIV: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= CW'(MAX_CHANNELS);
            r_h <= PW'(POS_RST);
        end else if (cfg_fire) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_CHANNELS:  r_c <= c_clamped;
                CFG_POSITIONS: r_h <= h_clamped;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
        end else if (cfg_fire && cfg_known) begin
            r_load_cnt <= '0;
        end else if (item_fire) begin
            r_load_cnt <= load_last ? '0 : r_load_cnt + TW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_MAC);
        end
    end

    // entry and address sequencing
    always_ff @(posedge i_clk) begin
        if (load_last) begin
            r_row    <= '0;
            r_col    <= '0;
            r_base_i <= '0;
            r_base_j <= '0;
            r_addr_a <= '0;
            r_addr_b <= '0;
            r_pos    <= '0;
        end else if (r_state == S_MAC) begin
            r_addr_a <= r_addr_a + AW'(1);
            r_addr_b <= r_addr_b + AW'(1);
            r_pos    <= r_pos + PW'(1);
        end else if (div_done && !entry_last) begin
            r_pos <= '0;
            if (col_last) begin
                r_row    <= r_row + IW'(1);
                r_col    <= '0;
                r_base_i <= r_base_i + AW'(r_h);
                r_base_j <= '0;
                r_addr_a <= r_base_i + AW'(r_h);
                r_addr_b <= '0;
            end else begin
                r_col    <= r_col + IW'(1);
                r_base_j <= r_base_j + AW'(r_h);
                r_addr_a <= r_base_i;
                r_addr_b <= r_base_j + AW'(r_h);
            end
        end
    end

    // result transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= div_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            r_value <= quo[OUT_W-1:0];
            r_row_o <= IDX_OUT_W'(r_row);
            r_col_o <= IDX_OUT_W'(r_col);
            r_last  <= entry_last;
        end
    end

    assign o_result_valid = r_res_vld;
    assign o_gram_value   = r_value;
    assign o_row_index    = r_row_o;
    assign o_col_index    = r_col_o;
    assign o_last_entry   = r_last;

    gmf_ram #(
        .WIDTH (FEAT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (item_fire),
        .i_waddr   (r_load_cnt[AW-1:0]),
        .i_wdata   (i_feature),
        .i_raddr_a (r_addr_a),
        .i_raddr_b (r_addr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    gmf_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_a     ($signed(rdata_a)),
        .i_b     ($signed(rdata_b)),
        .o_acc   (acc),
        .o_idle  (mac_idle)
    );

    gmf_div #(
        .DVD_W (ACC_W),
        .DVS_W (TW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (acc),
        .i_divisor  (total),
        .o_done     (div_done),
        .o_quotient (quo)
    );

`include "gram_matrix_forward_unit_defines.svh"

    `GMF_AST_IMP(a_strobe_busy, o_result_valid && !o_last_entry, o_busy)
    `GMF_AST_IMP(a_done_in_div, div_done, r_state == S_DIV)
    `GMF_AST_IMP(a_read_window, r_rd_vld, r_state == S_MAC || r_state == S_DRAIN)
    `GMF_AST_NXT(a_cfg_clears, cfg_fire && cfg_known, r_load_cnt == '0)

endmodule

### tb/gram_matrix_forward_checker.sv
// scoreboard for the gram matrix forward unit: watches the feature, result and config channels,
// predicts every normalized gram entry and compares it with what the block emits
// depends on gmf_pkg
module gram_matrix_forward_checker #(
    parameter int MAX_CHANNELS  = 8,
    parameter int MAX_POSITIONS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  gmf_pkg::t_feature                   i_feature,
    input  logic                                i_result_valid,
    input  logic signed [gmf_pkg::OUT_W-1:0]    i_gram_value,
    input  logic [gmf_pkg::IDX_OUT_W-1:0]       i_row_index,
    input  logic [gmf_pkg::IDX_OUT_W-1:0]       i_col_index,
    input  logic                                i_last_entry,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [gmf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gmf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                  o_mismatch_count,
    output int                                  o_pending_count
);
    import gmf_pkg::*;

    localparam int STORE_DEPTH = MAX_CHANNELS * MAX_POSITIONS;

    typedef struct {
        logic signed [OUT_W-1:0]  value;
        logic [IDX_OUT_W-1:0]     row;
        logic [IDX_OUT_W-1:0]     col;
        logic                     last;
    } t_gram_entry;

    t_feature               feature_store [STORE_DEPTH];
    int unsigned            load_count;
    logic [CHAN_FLD_W-1:0]  channels_reg;
    logic [CFG_DATA_W-1:0]  positions_reg;
    int unsigned            map_channels;
    int unsigned            map_positions;
    t_gram_entry            expected_entries [$];
    t_gram_entry            seen_entry;
    t_gram_entry            wanted_entry;

    function automatic int unsigned clamp_size(int unsigned value, int unsigned limit);
        if (value == 0) return 1;
        if (value > limit) return limit;
        return value;
    endfunction

    function automatic void queue_gram_matrix(int unsigned chans, int unsigned posns);
        longint      acc;
        t_gram_entry entry;
        for (int unsigned i = 0; i < chans; i++) begin
            for (int unsigned j = 0; j < chans; j++) begin
                acc = 0;
                for (int unsigned p = 0; p < posns; p++) begin
                    acc += longint'(feature_store[i * posns + p])
                         * longint'(feature_store[j * posns + p]);
                end
                // signed division truncates toward zero
                entry.value = OUT_W'(acc / longint'(chans * posns));
                entry.row   = IDX_OUT_W'(i);
                entry.col   = IDX_OUT_W'(j);
                entry.last  = (i == chans - 1) && (j == chans - 1);
                expected_entries.push_back(entry);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            load_count    = 0;
            channels_reg  = CHAN_FLD_W'(MAX_CHANNELS);
            positions_reg = CFG_DATA_W'(MAX_POSITIONS);
        end else begin
            if (i_result_valid) begin
                seen_entry.value = i_gram_value;
                seen_entry.row   = i_row_index;
                seen_entry.col   = i_col_index;
                seen_entry.last  = i_last_entry;
                if (expected_entries.size() == 0) begin
                    o_mismatch_count++;
                    $display("%0t: unexpected entry: value %0d row %0d col %0d last %0b",
                             $time, seen_entry.value, seen_entry.row, seen_entry.col,
                             seen_entry.last);
                end else begin
                    wanted_entry = expected_entries.pop_front();
                    if (seen_entry.value !== wanted_entry.value
                            || seen_entry.row !== wanted_entry.row
                            || seen_entry.col !== wanted_entry.col
                            || seen_entry.last !== wanted_entry.last) begin
                        o_mismatch_count++;
                        $display("%0t: gram entry mismatch", $time);
                        $display("    expected value %0d row %0d col %0d last %0b",
                                 wanted_entry.value, wanted_entry.row, wanted_entry.col,
                                 wanted_entry.last);
                        $display("    actual   value %0d row %0d col %0d last %0b",
                                 seen_entry.value, seen_entry.row, seen_entry.col,
                                 seen_entry.last);
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CHANNELS: begin
                        channels_reg = i_cfg_data[CHAN_FLD_W-1:0];
                        load_count   = 0;
                    end
                    CFG_POSITIONS: begin
                        positions_reg = i_cfg_data;
                        load_count    = 0;
                    end
                    default: begin
                    end
                endcase
            end

            if (i_start && !i_busy) begin
                map_channels  = clamp_size(channels_reg, MAX_CHANNELS);
                map_positions = clamp_size(positions_reg, MAX_POSITIONS);
                if (load_count >= map_channels * map_positions) load_count = 0;
                if (load_count < STORE_DEPTH) feature_store[load_count] = i_feature;
                load_count++;
                if (load_count == map_channels * map_positions) begin
                    load_count = 0;
                    queue_gram_matrix(map_channels, map_positions);
                end
            end
        end
        o_pending_count = expected_entries.size();
    end

endmodule

### tb/gram_matrix_forward_unit_test.sv
// top of the gram matrix forward unit regression: clock, reset, feature map and register stimulus
// depends on gmf_pkg, gram_matrix_forward_unit and gram_matrix_forward_checker
module gram_matrix_forward_unit_test;
    import gmf_pkg::*;

    localparam int     CLK_PERIOD       = 10;
    localparam int     MAX_CHANNELS     = 8;
    localparam int     MAX_POSITIONS    = 64;
    localparam int     PHASE_ITEMS      = 80;
    localparam longint RUN_LIMIT_CYCLES = 1_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

    localparam t_feature FEAT_MIN = 16'sh8000;
    localparam t_feature FEAT_MAX = 16'sh7FFF;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_start     = 1'b0;
    t_feature                       i_feature   = '0;
    logic                           i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]           i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]          i_cfg_data  = '0;
    logic                           o_busy;
    logic                           o_result_valid;
    logic signed [OUT_W-1:0]        o_gram_value;
    logic [IDX_OUT_W-1:0]           o_row_index;
    logic [IDX_OUT_W-1:0]           o_col_index;
    logic                           o_last_entry;
    logic                           o_cfg_ready;

    int          mismatch_count;
    int          pending_entries;
    int unsigned sender_idle_pct = 0;
    int unsigned features_sent   = 0;
    int unsigned maps_loaded     = 0;
    int unsigned register_writes = 0;
    int unsigned cur_channels    = MAX_CHANNELS;
    int unsigned cur_positions   = MAX_POSITIONS;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    gram_matrix_forward_unit #(
        .MAX_CHANNELS   (MAX_CHANNELS),
        .MAX_POSITIONS  (MAX_POSITIONS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_feature      (i_feature),
        .o_result_valid (o_result_valid),
        .o_gram_value   (o_gram_value),
        .o_row_index    (o_row_index),
        .o_col_index    (o_col_index),
        .o_last_entry   (o_last_entry),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    gram_matrix_forward_checker #(
        .MAX_CHANNELS   (MAX_CHANNELS),
        .MAX_POSITIONS  (MAX_POSITIONS)
    ) checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_busy           (o_busy),
        .i_feature        (i_feature),
        .i_result_valid   (o_result_valid),
        .i_gram_value     (o_gram_value),
        .i_row_index      (o_row_index),
        .i_col_index      (o_col_index),
        .i_last_entry     (o_last_entry),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_entries)
    );

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        register_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_map_size(input logic [CFG_DATA_W-1:0] chan_data,
                                input logic [CFG_DATA_W-1:0] posn_data);
        write_register(CFG_CHANNELS, chan_data);
        write_register(CFG_POSITIONS, posn_data);
    endtask

    // start stays high into the next transaction unless the sender idles
    task automatic send_feature(input t_feature value);
        i_start   <= 1'b1;
        i_feature <= value;
        do @(posedge i_clk); while (o_busy);
        features_sent++;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // wait for all entries to drain and the block to go quiet before a register write
    task automatic settle_block();
        i_start <= 1'b0;
        do @(negedge i_clk); while (pending_entries != 0 || o_busy);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_feature random_feature();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return FEAT_MIN;
        if (pick == 1) return FEAT_MAX;
        if (pick == 2) return t_feature'(int'($urandom_range(0, 31)) - 16);
        return t_feature'($urandom);
    endfunction

    task automatic load_features(input int unsigned count);
        repeat (count) send_feature(random_feature());
    endtask

    function automatic logic [CFG_DATA_W-1:0] encode_channels(input int unsigned chans);
        logic [CHAN_FLD_W-1:0] field;
        field = CHAN_FLD_W'(chans);
        if (chans == MAX_CHANNELS && $urandom_range(0, 1))
            field = CHAN_FLD_W'($urandom_range(8, 15));
        if (chans == 1 && $urandom_range(0, 1)) field = '0;
        return {3'($urandom), field};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] encode_positions(input int unsigned posns);
        if (posns == MAX_POSITIONS && $urandom_range(0, 1))
            return CFG_DATA_W'($urandom_range(64, 127));
        if (posns == 1 && $urandom_range(0, 1)) return '0;
        return CFG_DATA_W'(posns);
    endfunction

    task automatic run_random_phase(input int unsigned idle_pct, input int unsigned budget);
        int unsigned sent;
        int unsigned map_total;
        int unsigned partial;
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 9) < 6) begin
                settle_block();
                cur_channels  = $urandom_range(1, MAX_CHANNELS);
                cur_positions = (cur_channels <= 2 && $urandom_range(0, 3) == 0) ?
                                $urandom_range(7, MAX_POSITIONS) : $urandom_range(1, 6);
                set_map_size(encode_channels(cur_channels), encode_positions(cur_positions));
            end
            map_total = cur_channels * cur_positions;
            partial = (map_total > 1) ? $urandom_range(1, map_total - 1) : 0;
            case ($urandom_range(0, 9))
                0: begin
                    // partial map dropped by a rewrite of the size registers
                    if (partial != 0) begin
                        load_features(partial);
                        sent += partial;
                        settle_block();
                        set_map_size(encode_channels(cur_channels),
                                     encode_positions(cur_positions));
                    end
                    load_features(map_total);
                end
                1: begin
                    // unmapped register write in the middle of a map is ignored
                    load_features(partial);
                    settle_block();
                    write_register($urandom_range(0, 1) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI,
                                   CFG_DATA_W'($urandom));
                    load_features(map_total - partial);
                end
                default: load_features(map_total);
            endcase
            sent += map_total;
            maps_loaded++;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single element maps at the extremes, sizes written below range
        set_map_size('0, '0);
        send_feature(FEAT_MIN);
        send_feature(FEAT_MAX);
        maps_loaded += 2;

        // 2x2 map with opposing extremes, unmapped write mid-map
        settle_block();
        set_map_size(7'd2, 7'd2);
        send_feature(FEAT_MIN);
        send_feature(FEAT_MAX);
        settle_block();
        write_register(CFG_UNMAPPED_LO, 7'h7F);
        send_feature(FEAT_MAX);
        send_feature(FEAT_MIN);
        maps_loaded++;

        // channels above range, then a size write that drops a partial map
        settle_block();
        write_register(CFG_UNMAPPED_HI, 7'h55);
        set_map_size(7'h0C, 7'd1);
        send_feature(-16'sd1);
        send_feature(16'sd1);
        send_feature(16'sd0);
        settle_block();
        set_map_size(7'h78, 7'd1);
        send_feature(FEAT_MIN);
        send_feature(FEAT_MAX);
        send_feature(-16'sd1);
        send_feature(16'sd1);
        send_feature(16'sd3);
        send_feature(16'sh5555);
        send_feature(16'shAAAA);
        send_feature(16'sd0);
        maps_loaded++;
        cur_channels  = MAX_CHANNELS;
        cur_positions = 1;

        run_random_phase(30, PHASE_ITEMS);
        run_random_phase(75, PHASE_ITEMS);

        // longest rows: positions above range on two channels
        settle_block();
        sender_idle_pct = 0;
        set_map_size(7'd2, 7'h7F);
        load_features(2 * MAX_POSITIONS);
        maps_loaded++;
        cur_channels  = 2;
        cur_positions = MAX_POSITIONS;

        run_random_phase(0, PHASE_ITEMS);

        settle_block();
        repeat (200) @(posedge i_clk);
        $display("covered %0d feature transactions in %0d maps and %0d register writes",
                 features_sent, maps_loaded, register_writes);
        $display("maps from one element up to %0d channels and %0d positions, idling 30/75/0",
                 MAX_CHANNELS, MAX_POSITIONS);
        if (mismatch_count == 0 && pending_entries == 0) begin
            $display("gram_matrix_forward_unit regression: pass");
        end else begin
            $display("gram_matrix_forward_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("%0t: run limit reached, %0d entries outstanding", $time, pending_entries);
        $display("gram_matrix_forward_unit regression: fail");
        $finish;
    end

endmodule
